@@ hw/rtl/hse_pkg.sv @@
// Shared constants, command codes and payload types of the histogram statistics engine.
package hse_pkg;

    localparam int BIN_TOTAL   = 64;
    localparam int BIN_W       = $clog2(BIN_TOTAL);
    // Left edges are span*i*EDGE_SCALE in 1/256 units; BIN_TOTAL is a power of two up to 256
    localparam int EDGE_SCALE  = 256 / BIN_TOTAL;
    localparam int EDGE_SHIFT  = $clog2(EDGE_SCALE);
    localparam int DIV_CNT_W   = $clog2(BIN_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int TOT_W   = 38;
    localparam int SUMA_W  = 44;
    localparam int SUMB_W  = 50;
    localparam int WIDE_W  = 128;
    localparam int ENG_STEPS = 64;
    localparam int STEP_W  = $clog2(ENG_STEPS);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_STATS = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] sample;
        logic [5:0]         read_index;
    } hse_in_t;

    typedef struct packed {
        logic [5:0]         bin_number;
        logic [31:0]        bin_count;
        logic [37:0]        total_count;
        logic signed [23:0] mean_fx;
        logic [23:0]        sigma_fx;
        logic               empty_res;
        logic               range_error;
    } hse_out_t;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [BIN_W-1:0] bin;
    } hse_op_t;

    typedef struct packed {
        logic signed [15:0] low;
        logic [15:0]        span;
        logic               range_error;
    } hse_cfg_t;

endpackage

@@ hw/rtl/hse_front.sv @@
// Front end: accepts requests and works out the bin of each added sample.
module hse_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  hse_pkg::hse_cfg_t cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  hse_pkg::hse_in_t s_data,
    output logic             op_valid,
    input  logic             op_ready,
    output hse_pkg::hse_op_t op_data
);
    import hse_pkg::*;

    localparam logic [1:0] FR_IDLE = 2'd0;
    localparam logic [1:0] FR_DIV  = 2'd1;
    localparam logic [1:0] FR_PUSH = 2'd2;

    logic [1:0]           fst_reg, fst_next;
    hse_op_t              op_reg, op_next;
    logic [16:0]          rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [16:0]          diff;
    logic [16:0]          rem_sh;

    assign s_ready  = (fst_reg == FR_IDLE);
    assign op_valid = (fst_reg == FR_PUSH);
    assign op_data  = op_reg;

    always_comb begin
        fst_next = fst_reg;
        op_next  = op_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        diff     = 17'({s_data.sample[15], s_data.sample} - {cfg.low[15], cfg.low});
        rem_sh   = {rem_reg[15:0], 1'b0};
        case (fst_reg)
            FR_IDLE: begin
                if (s_valid) begin
                    op_next.cmd = s_data.cmd;
                    op_next.bin = '0;
                    fst_next    = FR_PUSH;
                    if (s_data.cmd == CMD_READ) begin
                        op_next.bin = BIN_W'(s_data.read_index);
                    end else if (s_data.cmd == CMD_ADD && !cfg.range_error &&
                                 s_data.sample > cfg.low) begin
                        if (diff[15:0] >= cfg.span) begin
                            op_next.bin = BIN_W'(BIN_TOTAL - 1);
                        end else begin
                            rem_next = {1'b0, diff[15:0]};
                            cnt_next = '0;
                            fst_next = FR_DIV;
                        end
                    end
                end
            end
            FR_DIV: begin
                // one quotient bit per cycle of BIN_TOTAL*off/span
                if (rem_sh >= {1'b0, cfg.span}) begin
                    rem_next    = rem_sh - {1'b0, cfg.span};
                    op_next.bin = {op_reg.bin[BIN_W-2:0], 1'b1};
                end else begin
                    rem_next    = rem_sh;
                    op_next.bin = {op_reg.bin[BIN_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(BIN_W - 1)) begin
                    fst_next = FR_PUSH;
                end
            end
            FR_PUSH: begin
                if (op_ready) begin
                    fst_next = FR_IDLE;
                end
            end
            default: fst_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fst_reg <= FR_IDLE;
        end else begin
            fst_reg <= fst_next;
        end
        op_reg  <= op_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule

@@ hw/rtl/hse_queue.sv @@
// Short request queue between front and back end.
module hse_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  hse_pkg::hse_op_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hse_pkg::hse_op_t out_data
);
    import hse_pkg::*;

    hse_op_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic              push, pop;

    assign in_ready  = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
        if (push) begin
            slot_reg[wr_reg] <= in_data;
        end
    end

endmodule

@@ hw/rtl/hse_back.sv @@
// Back end: bin memory, bin updates, reads and clears, and the stats sequencer.
module hse_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  hse_pkg::hse_cfg_t cfg,
    input  logic              op_valid,
    output logic              op_ready,
    input  hse_pkg::hse_op_t  op_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hse_pkg::hse_out_t m_data
);
    import hse_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ADD   = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_WRD   = 3'd3;
    localparam logic [2:0] ST_WACC  = 3'd4;
    localparam logic [2:0] ST_PLOAD = 3'd5;
    localparam logic [2:0] ST_PRUN  = 3'd6;
    localparam logic [2:0] ST_PEND  = 3'd7;

    // post-processing phases
    localparam logic [2:0] PH_TB   = 3'd0;
    localparam logic [2:0] PH_AA   = 3'd1;
    localparam logic [2:0] PH_VAR  = 3'd2;
    localparam logic [2:0] PH_SQRT = 3'd3;
    localparam logic [2:0] PH_SDIV = 3'd4;
    localparam logic [2:0] PH_S1   = 3'd5;
    localparam logic [2:0] PH_MDIV = 3'd6;

    logic [31:0]          mem [BIN_TOTAL];
    logic [31:0]          mem_rd_reg;
    logic                 vld_rd_reg;
    logic [BIN_TOTAL-1:0] vld_reg, vld_next;
    logic                 mem_we;
    logic [BIN_W-1:0]     mem_raddr;
    logic [31:0]          mem_wdata;

    logic [2:0]        st_reg, st_next;
    logic [2:0]        ph_reg, ph_next;
    hse_op_t           op_reg, op_next;
    logic [BIN_W-1:0]  idx_reg, idx_next;
    logic [TOT_W-1:0]  tot_reg, tot_next;
    logic [SUMA_W-1:0] suma_reg, suma_next;
    logic [SUMB_W-1:0] sumb_reg, sumb_next;
    logic [WIDE_W-1:0] p_reg, p_next;
    logic [WIDE_W-1:0] wa_reg, wa_next, wb_reg, wb_next, wc_reg, wc_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [23:0]       sig_reg, sig_next;
    logic              m_valid_reg, m_valid_next;
    hse_out_t          m_data_reg, m_data_next;

    logic [31:0]       cnt;
    logic [31:0]       cnt_inc;
    logic [37:0]       prod_a;
    logic [11:0]       idx_sq;
    logic [43:0]       prod_b;
    hse_out_t          res_base;
    logic [WIDE_W-1:0] sq_t;
    logic [TOT_W:0]    dv_r;
    logic              dv_ge;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign op_ready = (st_reg == ST_IDLE) && !m_valid_reg;

    always_comb begin
        cnt     = vld_rd_reg ? mem_rd_reg : '0;
        cnt_inc = (cnt == 32'hFFFF_FFFF) ? cnt : cnt + 32'd1;
        prod_a  = 38'(cnt) * 38'(idx_reg);
        idx_sq  = 12'(idx_reg) * 12'(idx_reg);
        prod_b  = 44'(cnt) * 44'(idx_sq);
        sq_t    = wc_reg + wb_reg;
        dv_r    = {wa_reg[TOT_W-1:0], wb_reg[63]};
        dv_ge   = (dv_r >= {1'b0, tot_reg});

        res_base             = '0;
        res_base.range_error = cfg.range_error;

        st_next      = st_reg;
        ph_next      = ph_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        tot_next     = tot_reg;
        suma_next    = suma_reg;
        sumb_next    = sumb_reg;
        p_next       = p_reg;
        wa_next      = wa_reg;
        wb_next      = wb_reg;
        wc_next      = wc_reg;
        step_next    = step_reg;
        sig_next     = sig_reg;
        vld_next     = vld_reg;
        mem_we       = 1'b0;
        mem_raddr    = idx_reg;
        mem_wdata    = cnt_inc;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        case (st_reg)
            ST_IDLE: begin
                mem_raddr = op_data.bin;
                if (op_valid && op_ready) begin
                    op_next = op_data;
                    case (op_data.cmd)
                        CMD_ADD:  st_next = ST_ADD;
                        CMD_READ: st_next = ST_READ;
                        CMD_STATS: begin
                            idx_next  = '0;
                            tot_next  = '0;
                            suma_next = '0;
                            sumb_next = '0;
                            st_next   = ST_WRD;
                        end
                        default: begin
                            vld_next     = '0;
                            m_valid_next = 1'b1;
                            m_data_next  = res_base;
                        end
                    endcase
                end
            end
            ST_ADD: begin
                mem_we                 = 1'b1;
                vld_next[op_reg.bin]   = 1'b1;
                m_valid_next           = 1'b1;
                m_data_next            = res_base;
                m_data_next.bin_number = 6'(op_reg.bin);
                m_data_next.bin_count  = cnt_inc;
                st_next                = ST_IDLE;
            end
            ST_READ: begin
                m_valid_next           = 1'b1;
                m_data_next            = res_base;
                m_data_next.bin_number = 6'(op_reg.bin);
                m_data_next.bin_count  = cnt;
                st_next                = ST_IDLE;
            end
            ST_WRD: begin
                st_next = ST_WACC;
            end
            ST_WACC: begin
                // accumulate count, i*count and i*i*count; edges scale in later
                tot_next  = tot_reg + TOT_W'(cnt);
                suma_next = suma_reg + SUMA_W'(prod_a);
                sumb_next = sumb_reg + SUMB_W'(prod_b);
                idx_next  = idx_reg + 1'b1;
                st_next   = ST_WRD;
                if (idx_reg == BIN_W'(BIN_TOTAL - 1)) begin
                    if (tot_next == '0) begin
                        m_valid_next          = 1'b1;
                        m_data_next           = res_base;
                        m_data_next.empty_res = 1'b1;
                        st_next               = ST_IDLE;
                    end else begin
                        ph_next = PH_TB;
                        st_next = ST_PLOAD;
                    end
                end
            end
            ST_PLOAD: begin
                wa_next   = '0;
                wc_next   = '0;
                step_next = '0;
                st_next   = ST_PRUN;
                case (ph_reg)
                    PH_TB: begin
                        wb_next = WIDE_W'(tot_reg);
                        wc_next = WIDE_W'(sumb_reg);
                    end
                    PH_AA: begin
                        wb_next = WIDE_W'(suma_reg);
                        wc_next = WIDE_W'(suma_reg);
                    end
                    PH_VAR: begin
                        wb_next = p_reg;
                        wc_next = WIDE_W'(32'(cfg.span) * 32'(cfg.span));
                    end
                    PH_SQRT: begin
                        wa_next = p_reg;
                        wb_next = WIDE_W'(1) << (WIDE_W - 2);
                    end
                    PH_SDIV: wb_next = WIDE_W'(p_reg[63:0]);
                    PH_S1: begin
                        wb_next = WIDE_W'(cfg.span);
                        wc_next = WIDE_W'(suma_reg);
                    end
                    default: wb_next = WIDE_W'(p_reg[63:0]);
                endcase
            end
            ST_PRUN: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(ENG_STEPS - 1)) begin
                    st_next = ST_PEND;
                end
                if (ph_reg == PH_SQRT) begin
                    if (wa_reg >= sq_t) begin
                        wa_next = wa_reg - sq_t;
                        wc_next = (wc_reg >> 1) + wb_reg;
                    end else begin
                        wc_next = wc_reg >> 1;
                    end
                    wb_next = wb_reg >> 2;
                end else if (ph_reg == PH_SDIV || ph_reg == PH_MDIV) begin
                    wa_next = dv_ge ? WIDE_W'(dv_r - {1'b0, tot_reg}) : WIDE_W'(dv_r);
                    wb_next = wb_reg << 1;
                    wc_next = {wc_reg[WIDE_W-2:0], dv_ge};
                end else begin
                    wa_next = wc_reg[0] ? wa_reg + wb_reg : wa_reg;
                    wb_next = wb_reg << 1;
                    wc_next = wc_reg >> 1;
                end
            end
            ST_PEND: begin
                ph_next = ph_reg + 1'b1;
                st_next = ST_PLOAD;
                case (ph_reg)
                    PH_TB:   p_next = wa_reg;
                    // clamp a negative variance to zero
                    PH_AA:   p_next = (p_reg > wa_reg) ? p_reg - wa_reg : '0;
                    PH_VAR:  p_next = wa_reg << (2 * EDGE_SHIFT);
                    PH_SQRT: p_next = wc_reg;
                    PH_SDIV: sig_next = (|wc_reg[63:24]) ? 24'hFF_FFFF : wc_reg[23:0];
                    PH_S1:   p_next = wa_reg << EDGE_SHIFT;
                    default: begin
                        m_valid_next            = 1'b1;
                        m_data_next             = res_base;
                        m_data_next.total_count = tot_reg;
                        m_data_next.mean_fx     = {cfg.low, 8'h00} + wc_reg[23:0];
                        m_data_next.sigma_fx    = sig_reg;
                        st_next                 = ST_IDLE;
                    end
                endcase
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[op_reg.bin] <= cnt_inc;
        end
        mem_rd_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
        vld_rd_reg <= vld_reg[mem_raddr];
        ph_reg     <= ph_next;
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        tot_reg    <= tot_next;
        suma_reg   <= suma_next;
        sumb_reg   <= sumb_next;
        p_reg      <= p_next;
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        wc_reg     <= wc_next;
        step_reg   <= step_next;
        sig_reg    <= sig_next;
        m_data_reg <= m_data_next;
    end

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.empty_res) |->
        (m_data_reg.total_count == '0 && m_data_reg.sigma_fx == '0))
        else $error("empty statistics with nonzero total or sigma");

    a_rerr_sigma: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.range_error) |-> (m_data_reg.sigma_fx == '0))
        else $error("nonzero sigma under range error");

    a_load_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_PLOAD) |=> (st_reg == ST_PRUN && step_reg == '0))
        else $error("engine did not start from step zero");

    a_add_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_ADD || st_reg == ST_READ) |-> ($past(st_reg) == ST_IDLE))
        else $error("bin access not launched from idle");

endmodule

@@ hw/rtl/histogram_stats_engine.sv @@
// Top level: range registers, front end, request queue and back end.
//
//  channel | ports                         | direction
//  --------+-------------------------------+----------
//  request | s_valid s_ready s_data        | in
//  result  | m_valid m_ready m_data        | out
//  config  | cfg_valid cfg_ready cfg_index | in
//          | cfg_data                      |
//
// Add: accept, plus bin division for an in-range sample in the front, then memory read
// and update in the back. Read: memory read, then result. Clear: resets the valid bits.
// Statistics: a walk over every bin, then 7 serial engine passes that run the bit-serial
// multiply, divide and square root.
// Reset clears all bins at once through per-bin valid bits; no clearing pass.
// The front keeps accepting until the queue is full while the back waits on m_ready.
module histogram_stats_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  hse_pkg::hse_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output hse_pkg::hse_out_t                  m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [15:0]                        cfg_data
);
    import hse_pkg::*;

    logic signed [15:0] low_reg, high_reg;
    logic [16:0]        diff;
    hse_cfg_t           cfg;
    logic               q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    hse_op_t            q_in_data, q_out_data;

    assign cfg_ready       = 1'b1;
    assign diff            = 17'({high_reg[15], high_reg} - {low_reg[15], low_reg});
    assign cfg.low         = low_reg;
    assign cfg.range_error = (high_reg <= low_reg);
    assign cfg.span        = cfg.range_error ? 16'd0 : diff[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= 16'sd0;
            high_reg <= 16'sd32767;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_RANGE_LOW:  low_reg  <= cfg_data;
                CFG_RANGE_HIGH: high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    hse_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .op_valid (q_in_valid),
        .op_ready (q_in_ready),
        .op_data  (q_in_data)
    );

    hse_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    hse_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .op_valid (q_out_valid),
        .op_ready (q_out_ready),
        .op_data  (q_out_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ bench/tb_histogram_stats_engine.sv @@
// Testbench for the histogram statistics engine: self-predicting, randomized, with backpressure.
`timescale 1ns / 100ps

module tb_histogram_stats_engine;
    import hse_pkg::*;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    hse_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    hse_out_t         m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]      cfg_data;

    histogram_stats_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int CYCLE_LIMIT = 10000000;

    // histogram mirror
    logic [31:0]        hist_bins [BIN_TOTAL];
    logic signed [15:0] hist_low;
    logic signed [15:0] hist_high;
    hse_out_t           pending_results [$];

    int mismatch_count;
    int cycle_count;
    int burst_left;
    int hold_request;
    int hold_left;
    int stall_mode;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [127:0] isqrt128(input logic [127:0] n);
        logic [127:0] root;
        logic [127:0] bitv;
        logic [127:0] rem;
        root = '0;
        rem  = n;
        bitv = 128'd1 << 126;
        while (bitv > rem && bitv != 0)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= root + bitv) begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic hse_out_t predict_histogram(input hse_in_t req);
        hse_out_t     r;
        logic         rerr;
        logic [63:0]  span;
        logic [63:0]  bin;
        logic [63:0]  edge_d;
        logic [63:0]  total;
        logic [127:0] sum1;
        logic [127:0] sum2;
        logic [127:0] var_num;
        logic [127:0] sig;
        logic signed [63:0] mean;
        r = '0;
        rerr = (hist_high <= hist_low);
        r.range_error = rerr;
        case (req.cmd)
            CMD_ADD: begin
                bin = '0;
                if (!rerr && req.sample > hist_low) begin
                    span = 64'(32'(hist_high) - 32'(hist_low));
                    bin  = (64'(BIN_TOTAL) * 64'(32'(req.sample) - 32'(hist_low))) / span;
                    if (bin >= 64'(BIN_TOTAL))
                        bin = 64'(BIN_TOTAL - 1);
                end
                if (hist_bins[bin] != 32'hFFFF_FFFF)
                    hist_bins[bin] = hist_bins[bin] + 32'd1;
                r.bin_number = bin[5:0];
                r.bin_count  = hist_bins[bin];
            end
            CMD_READ: begin
                r.bin_number = req.read_index;
                r.bin_count  = (req.read_index < BIN_TOTAL) ? hist_bins[req.read_index] : '0;
            end
            CMD_STATS: begin
                span  = rerr ? 64'd0 : 64'(32'(hist_high) - 32'(hist_low));
                total = '0;
                sum1  = '0;
                sum2  = '0;
                for (int i = 0; i < BIN_TOTAL; i++) begin
                    edge_d = (span * 64'd256 * 64'(i)) / 64'(BIN_TOTAL);
                    total  = total + 64'(hist_bins[i]);
                    sum1   = sum1 + 128'(edge_d) * 128'(hist_bins[i]);
                    sum2   = sum2 + 128'(edge_d) * 128'(edge_d) * 128'(hist_bins[i]);
                end
                if (total == 0) begin
                    r.empty_res = 1'b1;
                end else begin
                    mean = 64'(hist_low) * 256 + 64'(sum1 / 128'(total));
                    var_num = sum2 * 128'(total);
                    if (var_num > sum1 * sum1) begin
                        sig = isqrt128(var_num - sum1 * sum1) / 128'(total);
                        if (sig > 128'hFF_FFFF)
                            sig = 128'hFF_FFFF;
                    end else begin
                        sig = '0;
                    end
                    r.total_count = (total > 64'h3F_FFFF_FFFF) ? 38'h3F_FFFF_FFFF : total[37:0];
                    r.mean_fx     = mean[23:0];
                    r.sigma_fx    = sig[23:0];
                end
            end
            default: begin
                for (int i = 0; i < BIN_TOTAL; i++)
                    hist_bins[i] = '0;
            end
        endcase
        return r;
    endfunction

    function automatic bit field_ok(input string name, input logic [63:0] exp_v,
                                    input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            if (mismatch_count < 10)
                $display("mismatch %s: expected %0h, got %0h at cycle %0d",
                         name, exp_v, act_v, cycle_count);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // track accepted requests and config writes, check every result
    always @(posedge aclk) begin
        hse_out_t exp_r;
        bit ok;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_RANGE_LOW)
                    hist_low <= cfg_data;
                else
                    hist_high <= cfg_data;
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_histogram(s_data));
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected result at cycle %0d", cycle_count);
                    mismatch_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    ok = 1'b1;
                    ok &= field_ok("bin_number", exp_r.bin_number, m_data.bin_number);
                    ok &= field_ok("bin_count", exp_r.bin_count, m_data.bin_count);
                    ok &= field_ok("total_count", exp_r.total_count, m_data.total_count);
                    ok &= field_ok("mean_fx", exp_r.mean_fx, m_data.mean_fx);
                    ok &= field_ok("sigma_fx", exp_r.sigma_fx, m_data.sigma_fx);
                    ok &= field_ok("empty_res", exp_r.empty_res, m_data.empty_res);
                    ok &= field_ok("range_error", exp_r.range_error, m_data.range_error);
                    if (!ok)
                        mismatch_count++;
                end
            end
        end
    end

    // receiver: random stall pattern, plus long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (cycle_count % 150 == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 9) < 7);
                default: m_ready <= ($urandom_range(0, 9) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [15:0] sample,
                                input logic [5:0] idx);
        hse_in_t req;
        req.cmd = cmd;
        req.sample = sample;
        req.read_index = idx;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_requests();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_range(input logic signed [15:0] low, input logic signed [15:0] high);
        drain_requests();
        cfg_index <= CFG_RANGE_LOW;
        cfg_data  <= low;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_RANGE_HIGH;
        cfg_data  <= high;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_request(input int stats_pct);
        int roll;
        logic [15:0] smp;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            smp = 16'($urandom);
        else
            smp = 16'(32'(hist_low) + $urandom_range(0, 32'(hist_high) - 32'(hist_low) + 4));
        if (roll < stats_pct)
            send_request(CMD_STATS, 16'($urandom), 6'($urandom));
        else if (roll < stats_pct + 2)
            send_request(CMD_CLEAR, 16'($urandom), 6'($urandom));
        else if (roll < stats_pct + 20)
            send_request(CMD_READ, 16'($urandom), 6'($urandom));
        else
            send_request(CMD_ADD, smp, 6'($urandom));
    endtask

    task automatic test_directed();
        send_request(CMD_STATS, 16'h0000, 6'd0);
        send_request(CMD_ADD, 16'h8000, 6'd0);
        send_request(CMD_ADD, 16'h0000, 6'd0);
        send_request(CMD_ADD, 16'h7FFF, 6'd0);
        send_request(CMD_ADD, 16'h7FFE, 6'd63);
        send_request(CMD_ADD, 16'h4000, 6'h2A);
        send_request(CMD_READ, 16'hFFFF, 6'd0);
        send_request(CMD_READ, 16'h0000, 6'd63);
        send_request(CMD_READ, 16'h5555, 6'd32);
        send_request(CMD_STATS, 16'hFFFF, 6'd63);
        send_request(CMD_CLEAR, 16'h1234, 6'd5);
        send_request(CMD_READ, 16'h0000, 6'd0);
        send_request(CMD_STATS, 16'h0000, 6'd0);
        // a single bin gives zero sigma
        send_request(CMD_ADD, 16'h0100, 6'd0);
        send_request(CMD_ADD, 16'h0100, 6'd0);
        send_request(CMD_STATS, 16'h0000, 6'd0);
    endtask

    task automatic test_range_settings();
        write_range(16'sh8000, 16'sh7FFF);
        send_request(CMD_ADD, 16'h8000, 6'd0);
        send_request(CMD_ADD, 16'h7FFF, 6'd0);
        send_request(CMD_ADD, 16'hFFFF, 6'd0);
        send_request(CMD_STATS, 16'h0000, 6'd0);
        // equal edges: range error, everything lands in bin zero
        write_range(16'sd5, 16'sd5);
        send_request(CMD_ADD, 16'd100, 6'd0);
        send_request(CMD_READ, 16'd0, 6'd0);
        send_request(CMD_STATS, 16'd0, 6'd0);
        write_range(16'sd100, -16'sd100);
        send_request(CMD_ADD, 16'd50, 6'd0);
        send_request(CMD_STATS, 16'd0, 6'd0);
        send_request(CMD_CLEAR, 16'd0, 6'd0);
        // tiny span: more bins than samples; out-of-range samples land in the end bins
        write_range(-16'sd3, 16'sd3);
        for (int i = -5; i <= 5; i++)
            send_request(CMD_ADD, 16'(i), 6'd0);
        send_request(CMD_STATS, 16'd0, 6'd0);
    endtask

    task automatic test_random();
        logic signed [15:0] low;
        logic signed [15:0] high;
        for (int phase = 0; phase < 9; phase++) begin
            case (phase % 4)
                0: begin low = 16'($urandom); high = 16'($urandom); end
                1: begin low = 16'($urandom); high = 16'(32'(low) + $urandom_range(1, 200)); end
                2: begin low = 16'sh8000; high = 16'sh7FFF; end
                default: begin low = -16'sd1000; high = 16'sd1000; end
            endcase
            if (high <= low && phase % 4 != 0)
                high = 16'sh7FFF;
            write_range(low, high);
            repeat (180) send_random_request(4);
        end
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        repeat (30) send_random_request(0);
        repeat (20) send_random_request(3);
    endtask

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_RANGE_LOW;
        cfg_data  = '0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        hold_request = 0;
        hold_left = 0;
        stall_mode = 0;
        hist_low  = 16'sd0;
        hist_high = 16'sd32767;
        for (int i = 0; i < BIN_TOTAL; i++)
            hist_bins[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_range_settings();
        test_backpressure();
        test_random();
        drain_requests();
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/hse_pkg.sv
hw/rtl/hse_front.sv
hw/rtl/hse_queue.sv
hw/rtl/hse_back.sv
hw/rtl/histogram_stats_engine.sv
bench/tb_histogram_stats_engine.sv
